>>> rtl/positional_record_list_assert.svh
// Assertion macros for the positional record list.
// Used by positional_record_list.sv; expects clk and rst_n in scope.
`ifndef POSITIONAL_RECORD_LIST_ASSERT_SVH
`define POSITIONAL_RECORD_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_record_list: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_record_list: next-cycle check failed");

`endif

>>> rtl/prl_pkg.sv
// Shared types and constants for the positional record list.
// No dependencies; imported by prl_cell and positional_record_list.
package prl_pkg;

  localparam int CAPACITY = 64;
  localparam int K_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int ID_W     = 34;
  localparam int NAME_W   = 64;
  localparam int SCORE_W  = 16;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic        [NAME_W-1:0]  name;
    logic signed [SCORE_W-1:0] score;
  } rec_t;

  // Per-cell next-value select
  typedef enum logic [1:0] {
    SEL_KEEP    = 2'd0,
    SEL_FROM_LO = 2'd1,
    SEL_FROM_HI = 2'd2,
    SEL_LOAD    = 2'd3
  } cell_sel_t;

endpackage

>>> rtl/positional_record_list.sv
// Top level of the positional record list: control, cell chain, result register.
// Depends on prl_pkg, prl_cell and positional_record_list_assert.svh.
//
// An ordered list of up to CAPACITY records (id, packed name, signed score) kept in a
// chain of CAPACITY cells, cell 0 holding list position 1. Insert and delete move every
// affected cell one place, all in the same cycle. Find, get, delete and dump walk the
// list by rotating the whole chain through cell 0, one cell per cycle while the result
// side takes results, for exactly CAPACITY steps, so the chain is back in order when
// the walk ends. Count, insert and any rejected request are latched, then decided and
// answered; find, get and dump are latched, decided, walked for CAPACITY steps and
// finished; delete is latched, decided and walked to fetch the removed record, then
// shifts the chain in the finishing state. A stalled result side holds the walk.
// One request is in work at a time; in_tready is high only between requests. Results
// sit in one output register; out_tlast marks the final result of each request.
// Record cells have no reset: positions beyond the list length are never reported,
// and the block is usable from the first cycle after reset.
`include "positional_record_list_assert.svh"

module positional_record_list
  import prl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [127:0]        in_tdata,   // position[6:0], student_id[40:7],
                                          // name_key[104:41], score[120:105], zero above
  input  logic [CMD_W-1:0]    in_tuser,   // cmd[2:0]
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [127:0]        out_tdata,  // out_position[6:0], out_id[40:7],
                                          // out_name[104:41], out_score[120:105],
                                          // count[127:121]
  output logic [STATUS_W-1:0] out_tuser,  // status[2:0]
  output logic                out_tlast   // last
);

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // chain-wide move
  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_ROT  = 2'd1;
  localparam logic [1:0] MODE_INS  = 2'd2;
  localparam logic [1:0] MODE_DEL  = 2'd3;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [POS_W-1:0] CAP_LEN = POS_W'(CAPACITY);
  localparam logic [K_W-1:0]   K_LAST  = K_W'(CAPACITY - 1);

  // control registers
  logic [1:0]          state_r, state_nxt;
  logic [POS_W-1:0]    len_r, len_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                out_vld_r, out_vld_nxt;

  // latched request
  logic [CMD_W-1:0]    cmd_r;
  logic [POS_W-1:0]    pos_r;
  rec_t                req_r;

  // pending record (last find match, or record being deleted)
  rec_t                pend_r, pend_nxt;
  logic [POS_W-1:0]    pend_pos_r, pend_pos_nxt;

  // result register
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    out_pos_r;
  rec_t                out_rec_r;
  logic [POS_W-1:0]    out_count_r;
  logic                out_last_r;

  // result being pushed this cycle
  logic                push;
  logic [STATUS_W-1:0] p_status;
  logic [POS_W-1:0]    p_pos;
  rec_t                p_rec;
  logic [POS_W-1:0]    p_count;
  logic                p_last;

  logic [1:0]          mode;
  rec_t                cell_q [CAPACITY];
  rec_t                head;

  logic                accept;
  logic                out_free;
  logic [POS_W-1:0]    p_idx;
  logic [POS_W-1:0]    k_ext;
  logic [POS_W-1:0]    k_pos;
  logic                in_list;
  logic                scan_last;
  logic                name_hit;

  // decode of the latched request
  logic                dec_scan;
  logic                dec_ins_ok;
  logic [STATUS_W-1:0] dec_status;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_vld_r || out_tready;
  assign p_idx     = pos_r - POS_ONE;
  assign k_ext     = POS_W'(k_r);
  assign k_pos     = k_ext + POS_ONE;
  assign in_list   = k_ext < len_r;
  assign scan_last = (k_r == K_LAST);
  assign head      = cell_q[0];
  assign name_hit  = in_list && (head.name == req_r.name);

  // classify the request against the current length
  always_comb begin
    dec_scan   = 1'b0;
    dec_ins_ok = 1'b0;
    dec_status = ST_OK;
    unique case (cmd_r)
      CMD_INSERT: begin
        if ((pos_r == '0) || (pos_r > len_r + POS_ONE)) begin
          dec_status = ST_BADPOS;
        end else if (len_r >= CAP_LEN) begin
          dec_status = ST_FULL;
        end else begin
          dec_ins_ok = 1'b1;
        end
      end
      CMD_DELETE, CMD_GET: begin
        if ((pos_r == '0) || (pos_r > len_r)) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_scan = 1'b1;
        end
      end
      CMD_FIND: dec_scan = 1'b1;
      CMD_COUNT: dec_status = ST_OK;
      CMD_DUMP: begin
        if (len_r == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_scan = 1'b1;
        end
      end
      default: dec_status = ST_BADPOS;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    k_nxt        = k_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    pend_pos_nxt = pend_pos_r;
    mode         = MODE_KEEP;
    push         = 1'b0;
    p_status     = ST_OK;
    p_pos        = '0;
    p_rec        = '0;
    p_count      = len_r;
    p_last       = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        if (dec_scan) begin
          state_nxt    = S_SCAN;
          k_nxt        = '0;
          pend_vld_nxt = 1'b0;
        end else if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
          if (dec_ins_ok) begin
            // open a slot at pos and drop the new record in
            mode     = MODE_INS;
            len_nxt  = len_r + POS_ONE;
            p_count  = len_r + POS_ONE;
            p_pos    = pos_r;
            p_rec    = req_r;
          end else begin
            p_status = dec_status;
          end
        end
      end

      S_SCAN: begin
        // cell 0 holds list entry k this cycle
        logic emit;
        emit = 1'b0;
        unique case (cmd_r)
          CMD_FIND: begin
            emit    = name_hit && pend_vld_r;
            p_pos   = pend_pos_r;
            p_rec   = pend_r;
            p_last  = 1'b0;
          end
          CMD_DUMP: begin
            emit    = in_list;
            p_pos   = k_pos;
            p_rec   = head;
            p_last  = (k_pos == len_r);
          end
          CMD_GET: begin
            emit    = (k_ext == p_idx);
            p_pos   = k_pos;
            p_rec   = head;
          end
          default: emit = 1'b0;
        endcase

        if (!emit || out_free) begin
          push  = emit;
          mode  = MODE_ROT;
          k_nxt = scan_last ? '0 : k_r + K_W'(1);
          if (scan_last) begin
            state_nxt = S_FIN;
          end
          if ((cmd_r == CMD_FIND) && name_hit) begin
            pend_vld_nxt = 1'b1;
            pend_nxt     = head;
            pend_pos_nxt = k_pos;
          end
          if ((cmd_r == CMD_DELETE) && (k_ext == p_idx)) begin
            pend_vld_nxt = 1'b1;
            pend_nxt     = head;
            pend_pos_nxt = pos_r;
          end
        end
      end

      S_FIN: begin
        unique case (cmd_r)
          CMD_FIND: begin
            if (out_free) begin
              push      = 1'b1;
              state_nxt = S_IDLE;
              if (pend_vld_r) begin
                p_pos = pend_pos_r;
                p_rec = pend_r;
              end else begin
                p_status = ST_NOTFOUND;
              end
            end
          end
          CMD_DELETE: begin
            if (out_free) begin
              // close the gap at pos and report the removed record
              push      = 1'b1;
              state_nxt = S_IDLE;
              mode      = MODE_DEL;
              len_nxt   = len_r - POS_ONE;
              p_count   = len_r - POS_ONE;
              p_pos     = pend_pos_r;
              p_rec     = pend_r;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase

    if (push) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_sel_t cell_sel;

    always_comb begin
      unique case (mode)
        MODE_KEEP: cell_sel = SEL_KEEP;
        MODE_ROT:  cell_sel = SEL_FROM_HI;
        MODE_INS: begin
          if (POS_W'(i) > p_idx) begin
            cell_sel = SEL_FROM_LO;
          end else if (POS_W'(i) == p_idx) begin
            cell_sel = SEL_LOAD;
          end else begin
            cell_sel = SEL_KEEP;
          end
        end
        MODE_DEL: cell_sel = (POS_W'(i) >= p_idx) ? SEL_FROM_HI : SEL_KEEP;
        default:  cell_sel = SEL_KEEP;
      endcase
    end

    prl_cell u_cell (
      .clk      (clk),
      .sel      (cell_sel),
      .lo_rec   (cell_q[(i + CAPACITY - 1) % CAPACITY]),
      .hi_rec   (cell_q[(i + 1) % CAPACITY]),
      .load_rec (req_r),
      .rec_q    (cell_q[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      k_r        <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      k_r        <= k_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_tuser;
      pos_r       <= in_tdata[6:0];
      req_r.id    <= in_tdata[40:7];
      req_r.name  <= in_tdata[104:41];
      req_r.score <= in_tdata[120:105];
    end
    pend_r     <= pend_nxt;
    pend_pos_r <= pend_pos_nxt;
    if (push) begin
      out_status_r <= p_status;
      out_pos_r    <= p_pos;
      out_rec_r    <= p_rec;
      out_count_r  <= p_count;
      out_last_r   <= p_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_count_r, out_rec_r.score, out_rec_r.name, out_rec_r.id,
                       out_pos_r};

  // list never grows past the chain
  `PRL_ASSERT_IMP(a_len_cap, 1'b1, len_r <= CAP_LEN)
  // the walk counter is home whenever no walk runs, so the chain is back in order
  `PRL_ASSERT_IMP(a_walk_home, state_r != S_SCAN, k_r == '0)
  // a successful insert grows the list by exactly one
  `PRL_ASSERT_NXT(a_ins_len, push && (mode == MODE_INS), len_r == $past(len_r) + POS_ONE)
  // a failure or empty answer always closes the request
  `PRL_ASSERT_IMP(a_err_last, out_vld_r && (out_status_r != ST_OK), out_last_r)

endmodule

>>> rtl/prl_cell.sv
// One storage cell of the record chain: holds a single record.
// Depends on prl_pkg (rec_t, cell_sel_t).
module prl_cell
  import prl_pkg::*;
(
  input  logic      clk,
  input  cell_sel_t sel,
  input  rec_t      lo_rec,
  input  rec_t      hi_rec,
  input  rec_t      load_rec,
  output rec_t      rec_q
);

  rec_t rec_r;

  always_ff @(posedge clk) begin
    unique case (sel)
      SEL_KEEP:    rec_r <= rec_r;
      SEL_FROM_LO: rec_r <= lo_rec;
      SEL_FROM_HI: rec_r <= hi_rec;
      SEL_LOAD:    rec_r <= load_rec;
      default:     rec_r <= rec_r;
    endcase
  end

  assign rec_q = rec_r;

endmodule
